// File: sv/tkpq_pkg.sv
// ----------------------------------------------------------------------------
// tkpq_pkg
// Shared types, codes and helpers for the two-key priority queue.
// ----------------------------------------------------------------------------
package tkpq_pkg;

  localparam int unsigned QUEUE_DEPTH_DEF = 16;

  localparam int unsigned TAG_W    = 16;
  localparam int unsigned SEV_W    = 8;
  localparam int unsigned AGE_W    = 7;
  localparam int unsigned CLASS_W  = 3;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned OCC_W    = 5;
  localparam int unsigned APB_AW   = 3;
  localparam int unsigned APB_DW   = 32;

  // request codes
  localparam logic REQ_INSERT = 1'b0;
  localparam logic REQ_POP    = 1'b1;

  // result status codes
  localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

  // register index, taken from paddr[2]
  localparam logic REG_CHILD  = 1'b0;
  localparam logic REG_SENIOR = 1'b1;

  localparam logic [AGE_W-1:0] CHILD_LIMIT_RST  = 7'd12;
  localparam logic [AGE_W-1:0] SENIOR_LIMIT_RST = 7'd65;

  // age class codes, ordered so that a lower code is served first
  localparam logic [CLASS_W-1:0] CLASS_CHILD  = 3'd1;
  localparam logic [CLASS_W-1:0] CLASS_SENIOR = 3'd2;
  localparam logic [CLASS_W-1:0] CLASS_ADULT  = 3'd4;

  typedef struct packed {
    logic [TAG_W-1:0] tag;
    logic [SEV_W-1:0] sev;
    logic [AGE_W-1:0] age;
  } entry_t;

  // insert token walking down the cell row
  typedef struct packed {
    logic   vld;
    logic   shift;  // slot already found: carry displaced entries onward
    entry_t ent;
  } token_t;

  typedef enum logic {
    ST_IDLE,
    ST_WALK
  } state_e;

  function automatic logic [CLASS_W-1:0] age_class(
    input logic [AGE_W-1:0] age,
    input logic [AGE_W-1:0] child_lim,
    input logic [AGE_W-1:0] senior_lim
  );
    logic [CLASS_W-1:0] cls;
    if (age < child_lim) begin
      cls = CLASS_CHILD;
    end else if (age > senior_lim) begin
      cls = CLASS_SENIOR;
    end else begin
      cls = CLASS_ADULT;
    end
    return cls;
  endfunction

endpackage

// File: sv/tkpq_cell.sv
// ----------------------------------------------------------------------------
// tkpq_cell
// One slot of the sorted row: holds an entry and passes the insert token on.
// ----------------------------------------------------------------------------
module tkpq_cell
  import tkpq_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF,
  parameter int unsigned IDX         = 0,
  localparam int unsigned IDX_W      = $clog2(QUEUE_DEPTH)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [AGE_W-1:0] child_lim_i,
  input  logic [AGE_W-1:0] senior_lim_i,
  input  logic [IDX_W-1:0] tail_idx_i,
  input  logic             pop_i,
  input  entry_t           nb_ent_i,
  input  token_t           tok_i,
  output entry_t           ent_o,
  output token_t           tok_o
);

  token_t tok_q;
  entry_t ent_q, ent_d;
  logic   at_tail;
  logic   goes_here;

  assign at_tail = (tail_idx_i == IDX_W'(IDX));

  // held entry ranks at or behind the incoming one
  assign goes_here = (ent_q.sev > tok_q.ent.sev) ||
                     ((ent_q.sev == tok_q.ent.sev) &&
                      (age_class(ent_q.age, child_lim_i, senior_lim_i) >=
                       age_class(tok_q.ent.age, child_lim_i, senior_lim_i)));

  always_comb begin
    ent_d = ent_q;
    tok_o = '0;
    if (pop_i) begin
      ent_d = nb_ent_i;
    end else if (tok_q.vld) begin
      if (at_tail) begin
        // first free slot: absorb the token
        ent_d = tok_q.ent;
      end else if (tok_q.shift || goes_here) begin
        ent_d = tok_q.ent;
        tok_o = '{vld: 1'b1, shift: 1'b1, ent: ent_q};
      end else begin
        tok_o = tok_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q <= '0;
    end else begin
      tok_q <= tok_i;
    end
  end

  always_ff @(posedge clk_i) begin
    ent_q <= ent_d;
  end

  assign ent_o = ent_q;

endmodule

// File: sv/two_key_priority_queue.sv
// ----------------------------------------------------------------------------
// two_key_priority_queue
// Sorted queue keyed on severity, then age class; insert or pop per request.
// ----------------------------------------------------------------------------
//  channel  handshake                   payload
//  in       in_valid_i / in_stall_o     req_type, patient_tag, severity, age
//  out      out_valid_o / out_stall_i   status, served_*, occupancy
//  cfg      APB psel/penable/pwrite     child / senior age limit (7 bits)
//
//  An accepted request's result is registered and sits in the output register
//  the cycle after. A pop or a refused request frees the input at once. An
//  accepted insert then walks its token down the cell row, one cell a cycle,
//  and the input stays stalled until the token reaches the tail slot.
//  Reset clears control state only; slot contents are not cleared.
//  The input stalls while a result waits under out_stall_i or a walk runs.
// ----------------------------------------------------------------------------
module two_key_priority_queue
  import tkpq_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // config port
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [APB_AW-1:0]   paddr,
  input  logic [APB_DW-1:0]   pwdata,
  output logic [APB_DW-1:0]   prdata,
  output logic                pready,
  // request channel
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic                req_type_i,
  input  logic [TAG_W-1:0]    patient_tag_i,
  input  logic [SEV_W-1:0]    severity_i,
  input  logic [AGE_W-1:0]    age_i,
  // result channel
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [STATUS_W-1:0] status_o,
  output logic                served_valid_o,
  output logic [TAG_W-1:0]    served_tag_o,
  output logic [SEV_W-1:0]    served_severity_o,
  output logic [AGE_W-1:0]    served_age_o,
  output logic [OCC_W-1:0]    occupancy_o
);

  localparam int unsigned IDX_W = $clog2(QUEUE_DEPTH);
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

  // configuration registers
  logic [AGE_W-1:0] child_lim_q, senior_lim_q;
  logic             cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      child_lim_q  <= CHILD_LIMIT_RST;
      senior_lim_q <= SENIOR_LIMIT_RST;
    end else if (cfg_wr) begin
      case (paddr[2])
        REG_CHILD:  child_lim_q  <= pwdata[AGE_W-1:0];
        REG_SENIOR: senior_lim_q <= pwdata[AGE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_CHILD:  prdata = APB_DW'(child_lim_q);
      REG_SENIOR: prdata = APB_DW'(senior_lim_q);
      default:    prdata = '0;
    endcase
  end

  // control
  state_e           state_q, state_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic [IDX_W-1:0] walk_q, walk_d;
  logic [IDX_W-1:0] tail_q, tail_d;
  logic             in_acc;
  logic             is_full, is_empty;
  logic             do_insert, do_pop;
  logic             out_take;

  entry_t ent [QUEUE_DEPTH];
  token_t tok [QUEUE_DEPTH+1];

  assign is_full   = (count_q == CNT_W'(QUEUE_DEPTH));
  assign is_empty  = (count_q == '0);
  assign in_acc    = in_valid_i && !in_stall_o;
  assign do_insert = in_acc && (req_type_i == REQ_INSERT) && !is_full;
  assign do_pop    = in_acc && (req_type_i == REQ_POP) && !is_empty;

  // result register
  logic                out_valid_q;
  logic [STATUS_W-1:0] status_q;
  logic                served_valid_q;
  entry_t              served_q;
  logic [CNT_W-1:0]    occ_q;

  assign out_take = out_valid_q && !out_stall_i;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (do_insert) state_d = ST_WALK;
      ST_WALK: if (walk_q == tail_q) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // outputs of the state machine
  always_comb begin
    in_stall_o = 1'b1;
    walk_d     = '0;
    case (state_q)
      ST_IDLE: in_stall_o = out_valid_q && out_stall_i;
      ST_WALK: walk_d     = walk_q + IDX_W'(1);
      default: ;
    endcase
  end

  always_comb begin
    count_d = count_q;
    tail_d  = tail_q;
    if (do_insert) begin
      count_d = count_q + CNT_W'(1);
      tail_d  = IDX_W'(count_q);
    end else if (do_pop) begin
      count_d = count_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      walk_q      <= '0;
      tail_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      walk_q  <= walk_d;
      tail_q  <= tail_d;
      if (in_acc) begin
        out_valid_q <= 1'b1;
      end else if (out_take) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      served_valid_q <= do_pop;
      served_q       <= do_pop ? ent[0] : '0;
      occ_q          <= count_d;
      if (req_type_i == REQ_POP) begin
        status_q <= is_empty ? STATUS_EMPTY : STATUS_OK;
      end else begin
        status_q <= is_full ? STATUS_FULL : STATUS_OK;
      end
    end
  end

  assign out_valid_o       = out_valid_q;
  assign status_o          = status_q;
  assign served_valid_o    = served_valid_q;
  assign served_tag_o      = served_q.tag;
  assign served_severity_o = served_q.sev;
  assign served_age_o      = served_q.age;
  assign occupancy_o       = OCC_W'(occ_q);

  // cell row
  assign tok[0] = '{vld: do_insert, shift: 1'b0,
                    ent: '{tag: patient_tag_i, sev: severity_i, age: age_i}};

  for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
    entry_t nb_ent;
    if (g == QUEUE_DEPTH - 1) begin : g_last
      assign nb_ent = ent[g];
    end else begin : g_mid
      assign nb_ent = ent[g+1];
    end

    tkpq_cell #(
      .QUEUE_DEPTH (QUEUE_DEPTH),
      .IDX         (g)
    ) u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .child_lim_i  (child_lim_q),
      .senior_lim_i (senior_lim_q),
      .tail_idx_i   (tail_q),
      .pop_i        (do_pop),
      .nb_ent_i     (nb_ent),
      .tok_i        (tok[g]),
      .ent_o        (ent[g]),
      .tok_o        (tok[g+1])
    );
  end

  // checks
  a_tok_absorbed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !tok[QUEUE_DEPTH].vld)
    else $error("insert token ran off the end of the row");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(QUEUE_DEPTH))
    else $error("occupancy beyond queue depth");

  a_insert_walks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    do_insert |=> (state_q == ST_WALK) && (walk_q == '0) && tok[0].vld == 1'b0)
    else $error("insert did not start a walk at cell zero");

  a_walk_no_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_WALK) |-> !do_pop && !do_insert)
    else $error("request taken during a walk");

endmodule

// File: dv/tkpq_triage_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tkpq_triage_pkg
// Predictor and checker for the two-key priority queue: keeps its own sorted
// ward of entries and the queue of outcomes each accepted request must give.
// ----------------------------------------------------------------------------
package tkpq_triage_pkg;

  import tkpq_pkg::*;

  localparam int unsigned SLOTS = QUEUE_DEPTH_DEF;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic                served;
    logic [TAG_W-1:0]    tag;
    logic [SEV_W-1:0]    sev;
    logic [AGE_W-1:0]    age;
    logic [OCC_W-1:0]    occ;
  } outcome_t;

  class triage_board;
    entry_t           ward [SLOTS];
    int unsigned      ward_cnt;
    logic [AGE_W-1:0] child_lim;
    logic [AGE_W-1:0] senior_lim;
    outcome_t         awaited_outcomes [$];
    int unsigned      errors;
    int unsigned      n_requests;
    int unsigned      n_served;
    int unsigned      n_empty;
    int unsigned      n_full;

    function new();
      ward_cnt   = 0;
      child_lim  = CHILD_LIMIT_RST;
      senior_lim = SENIOR_LIMIT_RST;
      errors     = 0;
      n_requests = 0;
      n_served   = 0;
      n_empty    = 0;
      n_full     = 0;
    endfunction

    function void set_limits(logic [AGE_W-1:0] child, logic [AGE_W-1:0] senior);
      child_lim  = child;
      senior_lim = senior;
    endfunction

    // child wins where the two limits overlap
    function logic [CLASS_W-1:0] rank_of(logic [AGE_W-1:0] age);
      if (age < child_lim) begin
        return CLASS_CHILD;
      end
      if (age > senior_lim) begin
        return CLASS_SENIOR;
      end
      return CLASS_ADULT;
    endfunction

    function int unsigned pending();
      return awaited_outcomes.size();
    endfunction

    // work out the outcome of one accepted request and advance the ward
    function void admit(logic req, logic [TAG_W-1:0] tag, logic [SEV_W-1:0] sev,
                        logic [AGE_W-1:0] age);
      outcome_t           o;
      int unsigned        pos;
      int                 i;
      logic [CLASS_W-1:0] cls;
      o = '0;
      n_requests++;
      if (req == REQ_INSERT) begin
        if (ward_cnt >= SLOTS) begin
          o.status = STATUS_FULL;
          n_full++;
        end else begin
          cls = rank_of(age);
          pos = ward_cnt;
          // walk backwards so the first entry not ahead of the new one wins
          for (i = int'(ward_cnt) - 1; i >= 0; i--) begin
            if (ward[i].sev > sev || (ward[i].sev == sev && rank_of(ward[i].age) >= cls)) begin
              pos = unsigned'(i);
            end
          end
          for (i = int'(ward_cnt); i > int'(pos); i--) begin
            ward[i] = ward[i-1];
          end
          ward[pos] = '{tag: tag, sev: sev, age: age};
          ward_cnt++;
        end
      end else begin
        if (ward_cnt == 0) begin
          o.status = STATUS_EMPTY;
          n_empty++;
        end else begin
          o.status = STATUS_OK;
          o.served = 1'b1;
          o.tag    = ward[0].tag;
          o.sev    = ward[0].sev;
          o.age    = ward[0].age;
          for (i = 1; i < int'(ward_cnt); i++) begin
            ward[i-1] = ward[i];
          end
          ward_cnt--;
          n_served++;
        end
      end
      o.occ = ward_cnt[OCC_W-1:0];
      awaited_outcomes.push_back(o);
    endfunction

    function void compare(string name, logic [31:0] exp_val, logic [31:0] got_val);
      if (got_val !== exp_val) begin
        $error("%s: expected %0h, got %0h", name, exp_val, got_val);
        errors++;
      end
    endfunction

    function void check_served(outcome_t got);
      outcome_t exp_o;
      if (awaited_outcomes.size() == 0) begin
        $error("result beat with no request outstanding");
        errors++;
        return;
      end
      exp_o = awaited_outcomes.pop_front();
      compare("status", 32'(exp_o.status), 32'(got.status));
      compare("served_valid", 32'(exp_o.served), 32'(got.served));
      compare("served_tag", 32'(exp_o.tag), 32'(got.tag));
      compare("served_severity", 32'(exp_o.sev), 32'(got.sev));
      compare("served_age", 32'(exp_o.age), 32'(got.age));
      compare("occupancy", 32'(exp_o.occ), 32'(got.occ));
    endfunction
  endclass

endpackage

// File: dv/tb_two_key_priority_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_two_key_priority_queue
// Drives insert and pop requests through the queue, with and without random
// idling on both channels, reprograms the age limits between phases and checks
// every result beat against a sorted-ward predictor.
// ----------------------------------------------------------------------------
module tb_two_key_priority_queue;

  import tkpq_pkg::*;
  import tkpq_triage_pkg::*;

  localparam int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF;
  localparam int unsigned STUCK_LIMIT = 2000;
  localparam int unsigned PHASES      = 7;
  localparam int unsigned PHASE_ITEMS = 150;

  logic                clk_i          = 1'b0;
  logic                rst_ni         = 1'b0;
  logic                psel           = 1'b0;
  logic                penable        = 1'b0;
  logic                pwrite         = 1'b0;
  logic [APB_AW-1:0]   paddr          = '0;
  logic [APB_DW-1:0]   pwdata         = '0;
  logic [APB_DW-1:0]   prdata;
  logic                pready;
  logic                in_valid_i     = 1'b0;
  logic                in_stall_o;
  logic                req_type_i     = REQ_INSERT;
  logic [TAG_W-1:0]    patient_tag_i  = '0;
  logic [SEV_W-1:0]    severity_i     = '0;
  logic [AGE_W-1:0]    age_i          = '0;
  logic                out_valid_o;
  logic                out_stall_i    = 1'b0;
  logic [STATUS_W-1:0] status_o;
  logic                served_valid_o;
  logic [TAG_W-1:0]    served_tag_o;
  logic [SEV_W-1:0]    served_severity_o;
  logic [AGE_W-1:0]    served_age_o;
  logic [OCC_W-1:0]    occupancy_o;

  triage_board      board        = new();
  int unsigned      tx_idle_pct  = 0;
  int unsigned      rx_idle_pct  = 0;
  int unsigned      stuck_cycles = 0;
  int unsigned      n_settings   = 0;
  logic [AGE_W-1:0] cur_child    = CHILD_LIMIT_RST;
  logic [AGE_W-1:0] cur_senior   = SENIOR_LIMIT_RST;

  two_key_priority_queue #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) uut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .req_type_i       (req_type_i),
    .patient_tag_i    (patient_tag_i),
    .severity_i       (severity_i),
    .age_i            (age_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .status_o         (status_o),
    .served_valid_o   (served_valid_o),
    .served_tag_o     (served_tag_o),
    .served_severity_o(served_severity_o),
    .served_age_o     (served_age_o),
    .occupancy_o      (occupancy_o)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(0, 99) < rx_idle_pct);
  end

  // note request beats before checking result beats; watch for a hang
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        board.admit(req_type_i, patient_tag_i, severity_i, age_i);
      end
      if (out_valid_o && !out_stall_i) begin
        board.check_served({status_o, served_valid_o, served_tag_o, served_severity_o,
                            served_age_o, occupancy_o});
      end
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        stuck_cycles = 0;
      end else begin
        stuck_cycles++;
      end
      if (stuck_cycles >= STUCK_LIMIT) begin
        $error("no beat on either channel for %0d cycles", STUCK_LIMIT);
        $display("status: fail");
        $finish;
      end
    end
  end

  // hold the request until accepted; returns at the accepting edge
  task automatic send_request(logic req, logic [TAG_W-1:0] tag, logic [SEV_W-1:0] sev,
                              logic [AGE_W-1:0] age);
    if ($urandom_range(0, 99) < tx_idle_pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(0, 99) < tx_idle_pct);
    end
    in_valid_i    <= 1'b1;
    req_type_i    <= req;
    patient_tag_i <= tag;
    severity_i    <= sev;
    age_i         <= age;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  // drop valid, wait out every outstanding result and any insert walk
  task automatic settle_queue();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (board.pending() != 0) @(posedge clk_i);
    repeat (QUEUE_DEPTH + 4) @(posedge clk_i);
  endtask

  task automatic apb_write(logic idx, logic [AGE_W-1:0] val);
    logic [APB_DW-AGE_W-1:0] junk;
    junk    = (APB_DW-AGE_W)'($urandom());
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= {junk, val};
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    // leave the bus idle between transfers
    @(posedge clk_i);
  endtask

  task automatic set_limits(logic [AGE_W-1:0] child, logic [AGE_W-1:0] senior);
    apb_write(REG_CHILD, child);
    apb_write(REG_SENIOR, senior);
    board.set_limits(child, senior);
    cur_child  = child;
    cur_senior = senior;
    n_settings++;
  endtask

  // favour ages on either side of the class boundaries
  function automatic logic [AGE_W-1:0] pick_age();
    case ($urandom_range(0, 5))
      0: return cur_child - 1'b1;
      1: return cur_child;
      2: return cur_senior;
      3: return cur_senior + 1'b1;
      default: return AGE_W'($urandom_range(0, 127));
    endcase
  endfunction

  initial begin
    logic [AGE_W-1:0] child_set  [6];
    logic [AGE_W-1:0] senior_set [6];
    int unsigned      phase;
    int unsigned      k;
    int unsigned      ins_pct;
    logic [SEV_W-1:0] sev;

    child_set  = '{7'd0, 7'd127, 7'd100, 7'd0,   7'd127, 7'd12};
    senior_set = '{7'd0, 7'd127, 7'd20,  7'd127, 7'd0,   7'd65};
    ins_pct    = 50;

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    set_limits(CHILD_LIMIT_RST, SENIOR_LIMIT_RST);

    // directed: empty pop, class order, equal keys, boundaries, fill, overflow
    send_request(REQ_POP, TAG_W'($urandom()), SEV_W'($urandom()), AGE_W'($urandom()));
    send_request(REQ_INSERT, 16'hFFFF, 8'd255, 7'd127);
    send_request(REQ_INSERT, 16'h0000, 8'd0,   7'd0);
    send_request(REQ_INSERT, 16'h0001, 8'd5,   7'd40);
    send_request(REQ_INSERT, 16'h0002, 8'd5,   7'd70);
    send_request(REQ_INSERT, 16'h0003, 8'd5,   7'd3);
    send_request(REQ_INSERT, 16'h0004, 8'd5,   7'd40);
    send_request(REQ_INSERT, 16'h0005, 8'd5,   7'd12);
    send_request(REQ_INSERT, 16'h0006, 8'd5,   7'd11);
    send_request(REQ_INSERT, 16'h0007, 8'd5,   7'd65);
    send_request(REQ_INSERT, 16'h0008, 8'd5,   7'd66);
    send_request(REQ_INSERT, 16'h0009, 8'd255, 7'd127);
    send_request(REQ_INSERT, 16'hA5A5, 8'd0,   7'd127);
    send_request(REQ_INSERT, 16'h5A5A, 8'd128, 7'd64);
    send_request(REQ_INSERT, 16'h000A, 8'd5,   7'd40);
    send_request(REQ_INSERT, 16'h000B, 8'd200, 7'd0);
    send_request(REQ_INSERT, 16'h000C, 8'd1,   7'd100);
    send_request(REQ_INSERT, 16'h000D, 8'd0,   7'd0);
    repeat (7) begin
      send_request(REQ_POP, TAG_W'($urandom()), SEV_W'($urandom()), AGE_W'($urandom()));
    end
    settle_queue();

    for (phase = 0; phase < PHASES; phase++) begin
      if (phase < 2) begin
        tx_idle_pct = 38;
        rx_idle_pct = 45;
      end else if (phase < 4) begin
        tx_idle_pct = 45;
        rx_idle_pct = 38;
      end else begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      if (phase < 6) begin
        set_limits(child_set[phase], senior_set[phase]);
      end else begin
        set_limits(AGE_W'($urandom_range(0, 127)), AGE_W'($urandom_range(0, 127)));
      end
      for (k = 0; k < PHASE_ITEMS; k++) begin
        // swing the mix so the queue runs both full and empty
        if (k % 30 == 0) begin
          case ($urandom_range(0, 2))
            0: ins_pct = 15;
            1: ins_pct = 50;
            default: ins_pct = 85;
          endcase
        end
        sev = $urandom_range(0, 1) ? SEV_W'($urandom_range(0, 3))
                                   : SEV_W'($urandom_range(0, 255));
        if ($urandom_range(0, 99) < ins_pct) begin
          send_request(REQ_INSERT, TAG_W'($urandom()), sev, pick_age());
        end else begin
          send_request(REQ_POP, TAG_W'($urandom()), SEV_W'($urandom()),
                       AGE_W'($urandom()));
        end
      end
      settle_queue();
    end

    $display("covered %0d requests: %0d served, %0d pops on empty, %0d refused inserts",
             board.n_requests, board.n_served, board.n_empty, board.n_full);
    $display("over %0d age-limit settings, with idling on both channels and without",
             n_settings);
    if (board.errors == 0 && board.pending() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
